// File: sv/rpr_pkg.sv
// Shared types, widths and constant tables of the rotary position rotator.
// Holds the frequency ROM and CORDIC angle table, both built at elaboration.
// No dependencies.
package rpr_pkg;

  localparam int HEAD_SIZE     = 128;
  localparam int HALF_DIM      = HEAD_SIZE / 2;
  localparam int MAX_POSITION  = 32768;
  localparam int VAL_W         = 24;
  localparam int POS_W         = 15;
  localparam int IDX_W         = 6;
  localparam int ROM_DEPTH     = 1 << IDX_W;
  localparam int PHASE_W       = 32;
  localparam int GUARD_BITS    = 6;
  localparam int CORDIC_STAGES = 24;
  // Datapath width: 25 bits after negation, 6 guard bits, CORDIC growth and margin.
  localparam int XW            = VAL_W + 1 + GUARD_BITS + 3;
  localparam int GAIN_W        = 31;
  localparam int PW            = XW + GAIN_W;
  localparam int ROUND_SHIFT   = 30 + GUARD_BITS;
  localparam int SHW           = PW - ROUND_SHIFT;

  localparam longint unsigned LN_THETA_Q32 = 64'd59337166024;
  localparam longint unsigned LN2_Q32      = 64'd2977044472;
  localparam longint unsigned INV_2PI_Q32  = 64'd683565276;
  localparam logic signed [GAIN_W-1:0] CORDIC_GAIN_Q30 = 31'sd652032874;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [PHASE_W-1:0] freq_rom_t [ROM_DEPTH];
  typedef logic [PHASE_W-1:0] atan_rom_t [CORDIC_STAGES];

  typedef struct packed {
    logic signed [XW-1:0]      x;
    logic signed [XW-1:0]      y;
    logic signed [PHASE_W-1:0] z;
  } cordic_vec_t;

  // Restoring long division; only used while the tables are built.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Inverse frequency in turns per position: exp(-i*ln(theta)/half) / (2*pi).
  function automatic freq_rom_t build_freq_rom();
    freq_rom_t       rom;
    longint unsigned z;
    longint unsigned n;
    longint unsigned r;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    longint unsigned k;
    for (int idx = 0; idx < ROM_DEPTH; idx++) begin
      z    = div_u64(longint'(idx) * LN_THETA_Q32, 64'(HALF_DIM));
      n    = div_u64(z, LN2_Q32);
      r    = z - n * LN2_Q32;
      term = 64'd1 << 32;
      sum  = longint'(term);
      for (k = 1; k <= 20; k++) begin
        term = div_u64((term * r) >> 32, k);
        if (k[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * INV_2PI_Q32 + (64'd1 << 31)) >> 32;
      if (n >= 63) rom[idx] = '0;
      else         rom[idx] = PHASE_W'(v >> n);
    end
    return rom;
  endfunction

  // atan(2^-k) in turns; the first entry is exactly one eighth of a turn.
  function automatic atan_rom_t build_atan_rom();
    atan_rom_t       rom;
    longint          acc;
    longint unsigned t;
    longint unsigned rad32;
    int unsigned     n;
    rom[0] = PHASE_W'(64'd1 << 29);
    for (int unsigned k = 1; k < CORDIC_STAGES; k++) begin
      acc = 0;
      for (n = 0; k * (2 * n + 1) < 60; n++) begin
        t = div_u64(64'd1 << (60 - k * (2 * n + 1)), 64'(2 * n + 1));
        if (n[0]) acc = acc - longint'(t);
        else      acc = acc + longint'(t);
      end
      rad32  = longint'(acc) >> 28;
      rom[k] = PHASE_W'((rad32 * INV_2PI_Q32 + (64'd1 << 31)) >> 32);
    end
    return rom;
  endfunction

  localparam freq_rom_t FREQ_ROM   = build_freq_rom();
  localparam atan_rom_t ATAN_TURNS = build_atan_rom();

endpackage

// File: sv/rpr_if.sv
// Valid/ready channel interfaces for the rotator's input pairs and results.
// Depends on rpr_pkg for field widths.
interface rpr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [rpr_pkg::VAL_W-1:0] first_value;
  logic signed [rpr_pkg::VAL_W-1:0] second_value;
  logic        [rpr_pkg::POS_W-1:0] position;
  logic        [rpr_pkg::IDX_W-1:0] pair_index;
  modport source(output valid, first_value, second_value, position, pair_index,
                 input ready);
  modport sink(input valid, first_value, second_value, position, pair_index,
               output ready);
endinterface

interface rpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rpr_pkg::VAL_W-1:0] rotated_first;
  logic signed [rpr_pkg::VAL_W-1:0] rotated_second;
  modport source(output valid, rotated_first, rotated_second, input ready);
  modport sink(input valid, rotated_first, rotated_second, output ready);
endinterface

// File: sv/rpr_cordic.sv
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on rpr_pkg for the vector type and the angle table.
module rpr_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rpr_pkg::cordic_vec_t in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpr_pkg::cordic_vec_t out_vec
);

  localparam int N = rpr_pkg::CORDIC_STAGES;

  rpr_pkg::cordic_vec_t stage_r   [N];
  rpr_pkg::cordic_vec_t stage_nxt [N];
  logic [N-1:0]         v_r;
  logic [N-1:0]         v_nxt;
  logic [N:0]           en;

  // A stage may load when it is empty or its contents move on this cycle.
  assign en[N] = out_ready;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      rpr_pkg::cordic_vec_t src;
      logic                 src_v;
      logic signed [rpr_pkg::XW-1:0] xs;
      logic signed [rpr_pkg::XW-1:0] ys;
      if (g == 0) begin : g_first
        assign src   = in_vec;
        assign src_v = in_valid;
      end else begin : g_next
        assign src   = stage_r[g-1];
        assign src_v = v_r[g-1];
      end
      assign en[g] = !v_r[g] || en[g+1];
      assign xs    = src.x >>> g;
      assign ys    = src.y >>> g;

      always_comb begin
        stage_nxt[g] = src;
        if (!src.z[rpr_pkg::PHASE_W-1]) begin
          stage_nxt[g].x = src.x - ys;
          stage_nxt[g].y = src.y + xs;
          stage_nxt[g].z = src.z - $signed(rpr_pkg::ATAN_TURNS[g]);
        end else begin
          stage_nxt[g].x = src.x + ys;
          stage_nxt[g].y = src.y - xs;
          stage_nxt[g].z = src.z + $signed(rpr_pkg::ATAN_TURNS[g]);
        end
        v_nxt[g] = en[g] ? src_v : v_r[g];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else begin
          v_r[g] <= v_nxt[g];
        end
        if (en[g]) begin
          stage_r[g] <= stage_nxt[g];
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_vec   = stage_r[N-1];

endmodule

// File: sv/rotary_position_rotator.sv
// Top level of the rotary position rotator: frequency ROM, phase, quarter-turn
// pre-rotation, CORDIC and gain/saturation. Depends on rpr_pkg, rpr_if, rpr_cordic.
//
//  channel   direction  payload                                       handshake
//  in_ch     sink       first_value, second_value, position, pair_index valid/ready
//  out_ch    source     rotated_first, rotated_second                 valid/ready
//
// One pair enters per cycle while the output is not stalled; each result is
// presented through 29 register stages: three front stages, the 24 CORDIC
// micro-rotation stages and two gain stages.
// Reset clears only the stage valid bits; there is no state between pairs.
// Every stage loads when empty or when its contents move on, so a stalled
// output holds its result while earlier bubbles still fill and requests are taken.
module rotary_position_rotator (
  input  logic         clk,
  input  logic         rst_n,
  rpr_in_if.sink       in_ch,
  rpr_out_if.source    out_ch
);

  localparam int VW = rpr_pkg::VAL_W;
  localparam int PH = rpr_pkg::PHASE_W;
  localparam int XW = rpr_pkg::XW;

  // Stage 0: request registers and ROM lookup.
  logic                    v0_r, v0_nxt;
  logic signed [VW-1:0]    a0_r, b0_r;
  logic [rpr_pkg::POS_W-1:0] pos0_r;
  logic [PH-1:0]           rom0_r;
  // Stage 1: phase.
  logic                    v1_r, v1_nxt;
  logic signed [VW-1:0]    a1_r, b1_r;
  logic [PH-1:0]           phase1_r;
  // Stage 2: pre-rotated vector.
  logic                    v2_r, v2_nxt;
  rpr_pkg::cordic_vec_t    vec2_r, vec2_nxt;
  // Back end: gain products, then output.
  logic                    vp_r, vp_nxt;
  logic signed [rpr_pkg::PW-1:0] px_r, py_r;
  logic                    vo_r, vo_nxt;
  logic signed [VW-1:0]    ox_r, oy_r, ox_nxt, oy_nxt;

  logic en0, en1, en2, enp, eno;
  logic cordic_in_ready, cordic_out_valid;
  rpr_pkg::cordic_vec_t cordic_out;

  logic [rpr_pkg::POS_W-1:0] pos_mod;
  logic [PH-1:0]  phase_nxt;
  logic [PH-1:0]  phase_biased;
  logic [1:0]     quarter;
  logic [PH-1:0]  residual;
  logic signed [VW:0] a_ext, b_ext, a_rot, b_rot;

  assign eno = !vo_r || out_ch.ready;
  assign enp = !vp_r || eno;
  assign en2 = !v2_r || cordic_in_ready;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_ch.ready = en0;

  // The position range is a power of two, so it wraps by masking.
  assign pos_mod   = rpr_pkg::POS_W'(32'(in_ch.position) & (rpr_pkg::MAX_POSITION - 1));
  assign phase_nxt = PH'(pos0_r * rom0_r);

  // Nearest quarter turn; the residual stays within one eighth of a turn.
  always_comb begin
    phase_biased = phase1_r + PH'(1 << (PH - 3));
    quarter      = phase_biased[PH-1:PH-2];
    residual     = phase1_r - {quarter, {(PH-2){1'b0}}};
    a_ext        = (VW+1)'(a1_r);
    b_ext        = (VW+1)'(b1_r);
    case (quarter)
      2'd1: begin
        a_rot = -b_ext;
        b_rot = a_ext;
      end
      2'd2: begin
        a_rot = -a_ext;
        b_rot = -b_ext;
      end
      2'd3: begin
        a_rot = b_ext;
        b_rot = -a_ext;
      end
      default: begin
        a_rot = a_ext;
        b_rot = b_ext;
      end
    endcase
    vec2_nxt.x = XW'(a_rot) <<< rpr_pkg::GUARD_BITS;
    vec2_nxt.y = XW'(b_rot) <<< rpr_pkg::GUARD_BITS;
    vec2_nxt.z = $signed(residual);
  end

  function automatic logic signed [VW-1:0] round_sat(logic signed [rpr_pkg::PW-1:0] p);
    logic signed [rpr_pkg::PW-1:0]  s;
    logic signed [rpr_pkg::SHW-1:0] q;
    s = p + (rpr_pkg::PW'(1) <<< (rpr_pkg::ROUND_SHIFT - 1));
    q = rpr_pkg::SHW'(s >>> rpr_pkg::ROUND_SHIFT);
    if (q[rpr_pkg::SHW-1:VW-1] == '0 || q[rpr_pkg::SHW-1:VW-1] == '1) begin
      return q[VW-1:0];
    end else if (q[rpr_pkg::SHW-1]) begin
      return rpr_pkg::VAL_MIN;
    end else begin
      return rpr_pkg::VAL_MAX;
    end
  endfunction

  assign ox_nxt = round_sat(px_r);
  assign oy_nxt = round_sat(py_r);

  assign v0_nxt = en0 ? in_ch.valid : v0_r;
  assign v1_nxt = en1 ? v0_r : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign vp_nxt = enp ? cordic_out_valid : vp_r;
  assign vo_nxt = eno ? vp_r : vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vp_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vp_r <= vp_nxt;
      vo_r <= vo_nxt;
    end
    if (en0) begin
      a0_r   <= in_ch.first_value;
      b0_r   <= in_ch.second_value;
      pos0_r <= pos_mod;
      rom0_r <= rpr_pkg::FREQ_ROM[in_ch.pair_index];
    end
    if (en1) begin
      a1_r     <= a0_r;
      b1_r     <= b0_r;
      phase1_r <= phase_nxt;
    end
    if (en2) begin
      vec2_r <= vec2_nxt;
    end
    if (enp) begin
      px_r <= rpr_pkg::PW'(cordic_out.x) * rpr_pkg::PW'(rpr_pkg::CORDIC_GAIN_Q30);
      py_r <= rpr_pkg::PW'(cordic_out.y) * rpr_pkg::PW'(rpr_pkg::CORDIC_GAIN_Q30);
    end
    if (eno) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

  rpr_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (cordic_in_ready),
    .in_vec    (vec2_r),
    .out_valid (cordic_out_valid),
    .out_ready (enp),
    .out_vec   (cordic_out)
  );

  assign out_ch.valid          = vo_r;
  assign out_ch.rotated_first  = ox_r;
  assign out_ch.rotated_second = oy_r;

endmodule
